[hw/rtl/rtp_pkg.sv]
package rtp_pkg;

	// default signed width of numerator and denominator
	localparam int VALUE_BITS_DEF = 64;

	// character codes the parser reacts to
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// fraction digit count saturates here
	localparam logic [4:0] FRAC_CNT_MAX = 5'd31;

	typedef enum logic [1:0] {
		PH_SIGN = 2'd0,
		PH_INT  = 2'd1,
		PH_FRAC = 2'd2,
		PH_DEN  = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		ERR_OK        = 3'd0,
		ERR_BAD_START = 3'd1,
		ERR_BAD_INT   = 3'd2,
		ERR_BAD_FRAC  = 3'd3,
		ERR_BAD_DEN   = 3'd4,
		ERR_NO_NUMBER = 3'd5,
		ERR_NO_DEN    = 3'd6,
		ERR_TOO_LARGE = 3'd7
	} err_t;

	// parser control state, everything but the two magnitudes
	typedef struct packed {
		phase_t     phase;
		logic       negative;
		logic       den_negative;
		logic       digit_seen;
		logic       leading_dot;
		logic [4:0] frac_count;
		err_t       err;
		logic       ovf;
	} ctl_t;

	localparam ctl_t CTL_INIT = '{
		phase:        PH_SIGN,
		negative:     1'b0,
		den_negative: 1'b0,
		digit_seen:   1'b0,
		leading_dot:  1'b0,
		frac_count:   5'd0,
		err:          ERR_OK,
		ovf:          1'b0
	};

	// largest k with 10^k <= 2^(vb-1)-1, evaluated at elaboration
	function automatic int max_frac_digits(input int vb);
		logic [67:0] p;
		logic [67:0] lim;
		int          k;
		p   = 68'd1;
		lim = (68'd1 << (vb - 1)) - 68'd1;
		k   = 0;
		for (int i = 0; i < 19; i++) begin
			if (p * 68'd10 <= lim) begin
				p = p * 68'd10;
				k = k + 1;
			end
		end
		return k;
	endfunction

	// powers of ten for the fraction denominator
	function automatic logic [63:0] pow10(input logic [4:0] k);
		logic [63:0] r;
		case (k)
			5'd0:    r = 64'd1;
			5'd1:    r = 64'd10;
			5'd2:    r = 64'd100;
			5'd3:    r = 64'd1000;
			5'd4:    r = 64'd10000;
			5'd5:    r = 64'd100000;
			5'd6:    r = 64'd1000000;
			5'd7:    r = 64'd10000000;
			5'd8:    r = 64'd100000000;
			5'd9:    r = 64'd1000000000;
			5'd10:   r = 64'd10000000000;
			5'd11:   r = 64'd100000000000;
			5'd12:   r = 64'd1000000000000;
			5'd13:   r = 64'd10000000000000;
			5'd14:   r = 64'd100000000000000;
			5'd15:   r = 64'd1000000000000000;
			5'd16:   r = 64'd10000000000000000;
			5'd17:   r = 64'd100000000000000000;
			5'd18:   r = 64'd1000000000000000000;
			default: r = 64'd0;
		endcase
		return r;
	endfunction

endpackage

[hw/rtl/rtp_step.sv]
module rtp_step import rtp_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  ctl_t                         cur_ctl,
	input  logic [VALUE_BITS-2:0]        cur_accum,
	input  logic [VALUE_BITS-2:0]        cur_saved,
	input  logic [7:0]                   ch,
	output ctl_t                         nxt_ctl,
	output logic [VALUE_BITS-2:0]        nxt_accum,
	output logic [VALUE_BITS-2:0]        nxt_saved,
	output logic signed [VALUE_BITS-1:0] numer,
	output logic signed [VALUE_BITS-1:0] denom,
	output logic [2:0]                   error
);

	localparam int PW       = VALUE_BITS + 3;
	localparam int MAX_FRAC = max_frac_digits(VALUE_BITS);
	localparam logic [PW-1:0] LIMIT = {4'b0, {(VALUE_BITS-1){1'b1}}};

	logic          is_dig;
	logic [7:0]    dsub;
	logic [PW-1:0] prod;
	logic          over;
	logic          take;
	err_t          fin_err;
	logic [VALUE_BITS-1:0] num_mag;
	logic [VALUE_BITS-1:0] acc_ext;
	logic [63:0]   pw10;

	// digit decode and accum*10+d with range check
	assign is_dig = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign dsub   = ch - CH_ZERO;
	assign prod   = ({4'b0, cur_accum} << 3) + ({4'b0, cur_accum} << 1) + PW'(dsub[3:0]);
	assign over   = prod > LIMIT;

	// one character of the parse
	always_comb begin
		nxt_ctl   = cur_ctl;
		nxt_accum = cur_accum;
		nxt_saved = cur_saved;
		take      = 1'b0;
		if (cur_ctl.err == ERR_OK) begin
			case (cur_ctl.phase)
				PH_SIGN: begin
					if (ch == CH_MINUS) begin
						nxt_ctl.negative = 1'b1;
						nxt_ctl.phase    = PH_INT;
					end else if (ch == CH_PLUS) begin
						nxt_ctl.phase = PH_INT;
					end else if (is_dig) begin
						take          = 1'b1;
						nxt_ctl.phase = PH_INT;
					end else if (ch == CH_DOT) begin
						nxt_ctl.leading_dot = 1'b1;
						nxt_ctl.phase       = PH_FRAC;
					end else begin
						nxt_ctl.err = ERR_BAD_START;
					end
				end
				PH_INT: begin
					if (is_dig) begin
						take = 1'b1;
					end else if (ch == CH_DOT) begin
						nxt_ctl.phase = PH_FRAC;
					end else if (ch == CH_SLASH) begin
						if (!cur_ctl.digit_seen) begin
							nxt_ctl.err = ERR_NO_NUMBER;
						end else if (cur_ctl.ovf) begin
							nxt_ctl.err = ERR_TOO_LARGE;
						end else begin
							nxt_saved          = cur_accum;
							nxt_accum          = '0;
							nxt_ctl.digit_seen = 1'b0;
							nxt_ctl.phase      = PH_DEN;
						end
					end else begin
						nxt_ctl.err = ERR_BAD_INT;
					end
				end
				PH_FRAC: begin
					if (!is_dig) begin
						nxt_ctl.err = ERR_BAD_FRAC;
					end else begin
						take = 1'b1;
						if (cur_ctl.frac_count != FRAC_CNT_MAX)
							nxt_ctl.frac_count = cur_ctl.frac_count + 5'd1;
					end
				end
				PH_DEN: begin
					if (!cur_ctl.digit_seen && ch == CH_PLUS) begin
						nxt_ctl.den_negative = cur_ctl.den_negative;
					end else if (!cur_ctl.digit_seen && ch == CH_MINUS) begin
						nxt_ctl.den_negative = 1'b1;
					end else if (!is_dig) begin
						nxt_ctl.err = ERR_BAD_DEN;
					end else begin
						take = 1'b1;
					end
				end
				default: begin
					nxt_ctl.err = ERR_BAD_START;
				end
			endcase
		end
		// digit accumulate; magnitude freezes once it passes the limit
		if (take) begin
			nxt_ctl.digit_seen = 1'b1;
			if (!cur_ctl.ovf) begin
				if (over)
					nxt_ctl.ovf = 1'b1;
				else
					nxt_accum = prod[VALUE_BITS-2:0];
			end
		end
	end

	// end-of-string result, used only on the last beat
	assign acc_ext = {1'b0, nxt_accum};
	assign pw10    = pow10(nxt_ctl.frac_count);

	always_comb begin
		fin_err = nxt_ctl.err;
		num_mag = '0;
		denom   = '0;
		if (fin_err == ERR_OK) begin
			case (nxt_ctl.phase)
				PH_SIGN, PH_INT: begin
					if (!nxt_ctl.digit_seen) begin
						fin_err = ERR_NO_NUMBER;
					end else if (nxt_ctl.ovf) begin
						fin_err = ERR_TOO_LARGE;
					end else begin
						num_mag = acc_ext;
						denom   = VALUE_BITS'(1);
					end
				end
				PH_FRAC: begin
					if (!nxt_ctl.digit_seen && !nxt_ctl.leading_dot) begin
						fin_err = ERR_NO_NUMBER;
					end else if (nxt_ctl.ovf) begin
						fin_err = ERR_TOO_LARGE;
					end else if (nxt_ctl.frac_count > 5'(MAX_FRAC)) begin
						fin_err = ERR_TOO_LARGE;
					end else begin
						num_mag = acc_ext;
						denom   = pw10[VALUE_BITS-1:0];
					end
				end
				PH_DEN: begin
					if (!nxt_ctl.digit_seen) begin
						fin_err = ERR_NO_DEN;
					end else if (nxt_ctl.ovf) begin
						fin_err = ERR_TOO_LARGE;
					end else begin
						num_mag = {1'b0, nxt_saved};
						denom   = nxt_ctl.den_negative ? -acc_ext : acc_ext;
					end
				end
				default: begin
					fin_err = ERR_BAD_START;
				end
			endcase
		end
	end

	assign numer = nxt_ctl.negative ? -num_mag : num_mag;
	assign error = fin_err;

endmodule

[hw/rtl/rational_text_parser_top.sv]
// Channel  | Dir | Beat content
// s_axis   | in  | tdata[7:0] = ch, tlast = last (final character)
// m_axis   | out | tdata = numer, denom, error (low bits up), zero padded to bytes
//
// One character per cycle unless stalled as below; the step logic sits between the input
// register and the result register.
// A result is valid once its last character has passed the input register and the result register.
// Input stalls only when a finished result has not yet been taken and the
// registered character is itself a last character.
// arst_n clears the parse state, the input valid and the result valid.
module rational_text_parser_top import rtp_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	localparam int OUT_W = ((2 * VALUE_BITS + 3 + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [7:0]       s_axis_tdata,   // [7:0] ch
	input  logic             s_axis_tlast,   // last
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata    // numer, denom, error, zero pad
);

	localparam int PAD_W = OUT_W - (2 * VALUE_BITS + 3);

	logic       v_s1;
	logic [7:0] ch_s1;
	logic       last_s1;
	logic       adv;

	ctl_t                  ctl_q;
	logic [VALUE_BITS-2:0] accum_q;
	logic [VALUE_BITS-2:0] saved_q;

	ctl_t                  ctl_d;
	logic [VALUE_BITS-2:0] accum_d;
	logic [VALUE_BITS-2:0] saved_d;
	logic [VALUE_BITS-1:0] numer_d;
	logic [VALUE_BITS-1:0] denom_d;
	logic [2:0]            error_d;

	logic                  ov_q;
	logic [VALUE_BITS-1:0] numer_q;
	logic [VALUE_BITS-1:0] denom_q;
	logic [2:0]            error_q;

	// stage advances unless a last beat would overwrite an untaken result
	assign adv           = v_s1 && (!last_s1 || !ov_q || m_axis_tready);
	assign s_axis_tready = !v_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			ch_s1   <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	rtp_step #(
		.VALUE_BITS(VALUE_BITS)
	) u_step (
		.cur_ctl   (ctl_q),
		.cur_accum (accum_q),
		.cur_saved (saved_q),
		.ch        (ch_s1),
		.nxt_ctl   (ctl_d),
		.nxt_accum (accum_d),
		.nxt_saved (saved_d),
		.numer     (numer_d),
		.denom     (denom_d),
		.error     (error_d)
	);

	// parse state; back to initial after each last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q   <= CTL_INIT;
			accum_q <= '0;
			saved_q <= '0;
		end else if (adv) begin
			if (last_s1) begin
				ctl_q   <= CTL_INIT;
				accum_q <= '0;
				saved_q <= '0;
			end else begin
				ctl_q   <= ctl_d;
				accum_q <= accum_d;
				saved_q <= saved_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (adv && last_s1) begin
			ov_q <= 1'b1;
		end else if (m_axis_tready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			numer_q <= numer_d;
			denom_q <= denom_d;
			error_q <= error_d;
		end
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, error_q, denom_q, numer_q};

	// an error result carries zero numerator and denominator
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && error_q != ERR_OK) |-> (numer_q == '0 && denom_q == '0))
		else $error("error result with nonzero payload");

	// a recorded error sticks until the string ends
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_q.err != ERR_OK && !(adv && last_s1)) |=> (ctl_q.err == $past(ctl_q.err)))
		else $error("parse error code changed mid-string");

	// a new result appears only after a last character was processed
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ov_q) |-> $past(adv && last_s1))
		else $error("result without last character");

	// a held last character means the result slot is still occupied
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv) |-> (last_s1 && ov_q && !m_axis_tready))
		else $error("input stage stalled without cause");

endmodule

[test/rational_text_parser_top_tb.sv]
`timescale 1ns / 100ps

module rational_text_parser_top_tb;
	import rtp_pkg::*;

	localparam int VB = VALUE_BITS_DEF;
	localparam int OUT_W = ((2 * VB + 3 + 7) / 8) * 8;
	localparam logic [63:0] MAG_LIM = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] NEG_MAX = 64'h8000_0000_0000_0001;
	localparam logic [63:0] E18 = 64'd1000000000000000000;
	localparam int TEXT_ITEMS = 1400;
	localparam int CYCLE_LIMIT = 400000;
	localparam int N_DIR = 28;

	// expected result of one string
	typedef struct packed {
		logic [63:0] numer;
		logic [63:0] denom;
		err_t        err;
	} rat_res_t;

	// one directed string; known rows carry a hand-typed result
	typedef struct {
		string       txt;
		bit          known;
		logic [63:0] numer;
		logic [63:0] denom;
		err_t        err;
	} dir_row_t;

	logic             clk;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [7:0]       s_axis_tdata;   // [7:0] ch
	logic             s_axis_tlast;   // last
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;   // numer, denom, error, zero pad

	rat_res_t rat_expect_q[$];
	int       fails = 0;
	int       n_chars = 0;
	int       n_texts = 0;
	int       n_results = 0;
	int       err_hist[8];
	int       cyc = 0;
	bit       snd_burst = 0;
	bit       rcv_burst = 0;

	// parser state as the predictor sees it
	phase_t      p_ph;
	err_t        p_err;
	logic [63:0] p_acc;
	logic [63:0] p_num;
	bit          p_neg;
	bit          p_dneg;
	bit          p_dig;
	bit          p_ldot;
	bit          p_ovf;
	logic [4:0]  p_fcnt;

	dir_row_t dir_tab [N_DIR] = '{
		'{"0",                      1, 64'd0,   64'd1, ERR_OK},
		'{"9",                      1, 64'd9,   64'd1, ERR_OK},
		'{".",                      1, 64'd0,   64'd1, ERR_OK},
		'{"-.",                     1, 64'd0,   64'd0, ERR_NO_NUMBER},
		'{"5.",                     0, 64'd0,   64'd0, ERR_OK},
		'{"-",                      1, 64'd0,   64'd0, ERR_NO_NUMBER},
		'{"+",                      1, 64'd0,   64'd0, ERR_NO_NUMBER},
		'{"-/3",                    1, 64'd0,   64'd0, ERR_NO_NUMBER},
		'{"x",                      1, 64'd0,   64'd0, ERR_BAD_START},
		'{"/",                      1, 64'd0,   64'd0, ERR_BAD_START},
		'{"\377",                   1, 64'd0,   64'd0, ERR_BAD_START},
		'{"1a2",                    1, 64'd0,   64'd0, ERR_BAD_INT},
		'{"1.x",                    1, 64'd0,   64'd0, ERR_BAD_FRAC},
		'{"1.5/2",                  1, 64'd0,   64'd0, ERR_BAD_FRAC},
		'{"1/x",                    1, 64'd0,   64'd0, ERR_BAD_DEN},
		'{"1/",                     1, 64'd0,   64'd0, ERR_NO_DEN},
		'{"1/+-+2",                 0, 64'd0,   64'd0, ERR_OK},
		'{"-7/0",                   0, 64'd0,   64'd0, ERR_OK},
		'{"9223372036854775807",    1, MAG_LIM, 64'd1, ERR_OK},
		'{"-9223372036854775807",   1, NEG_MAX, 64'd1, ERR_OK},
		'{"9223372036854775808",    1, 64'd0,   64'd0, ERR_TOO_LARGE},
		'{"99999999999999999999/2", 1, 64'd0,   64'd0, ERR_TOO_LARGE},
		'{"99999999999999999999z",  1, 64'd0,   64'd0, ERR_BAD_INT},
		'{".000000000000000001",    1, 64'd1,   E18,   ERR_OK},
		'{".0000000000000000001",   1, 64'd0,   64'd0, ERR_TOO_LARGE},
		'{"+12.50",                 0, 64'd0,   64'd0, ERR_OK},
		'{"-.5",                    0, 64'd0,   64'd0, ERR_OK},
		'{"3/9223372036854775808",  1, 64'd0,   64'd0, ERR_TOO_LARGE}
	};

	rational_text_parser_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	task automatic parse_clear();
		p_ph   = PH_SIGN;
		p_err  = ERR_OK;
		p_acc  = '0;
		p_num  = '0;
		p_neg  = 0;
		p_dneg = 0;
		p_dig  = 0;
		p_ldot = 0;
		p_ovf  = 0;
		p_fcnt = '0;
	endtask

	// accumulate one decimal digit, sticky overflow past the magnitude limit
	task automatic add_digit(input logic [7:0] d);
		p_dig = 1;
		if (!p_ovf) begin
			if (p_acc > (MAG_LIM - 64'(d)) / 64'd10)
				p_ovf = 1;
			else
				p_acc = p_acc * 64'd10 + 64'(d);
		end
	endtask

	// one character through the parser; a final character yields the rational
	task automatic parse_step(input logic [7:0] c, input bit lst, output bit got,
			output rat_res_t res);
		bit          isdig;
		logic [7:0]  d;
		logic [63:0] n;
		logic [63:0] dn;
		logic [63:0] p;
		isdig = (c >= CH_ZERO) && (c <= CH_NINE);
		d = c - CH_ZERO;
		got = 0;
		res = '{64'd0, 64'd0, ERR_OK};
		if (p_err == ERR_OK) begin
			case (p_ph)
				PH_SIGN: begin
					if (c == CH_MINUS) begin
						p_neg = 1;
						p_ph = PH_INT;
					end else if (c == CH_PLUS) begin
						p_ph = PH_INT;
					end else if (isdig) begin
						add_digit(d);
						p_ph = PH_INT;
					end else if (c == CH_DOT) begin
						p_ldot = 1;
						p_ph = PH_FRAC;
					end else begin
						p_err = ERR_BAD_START;
					end
				end
				PH_INT: begin
					if (isdig) begin
						add_digit(d);
					end else if (c == CH_DOT) begin
						p_ph = PH_FRAC;
					end else if (c == CH_SLASH) begin
						if (!p_dig)
							p_err = ERR_NO_NUMBER;
						else if (p_ovf)
							p_err = ERR_TOO_LARGE;
						else begin
							p_num = p_acc;
							p_acc = '0;
							p_dig = 0;
							p_ph = PH_DEN;
						end
					end else begin
						p_err = ERR_BAD_INT;
					end
				end
				PH_FRAC: begin
					if (!isdig) begin
						p_err = ERR_BAD_FRAC;
					end else begin
						add_digit(d);
						if (p_fcnt != FRAC_CNT_MAX)
							p_fcnt = p_fcnt + 5'd1;
					end
				end
				default: begin
					// any run of signs ahead of the first denominator digit
					if (!p_dig && c == CH_MINUS)
						p_dneg = 1;
					else if (!(!p_dig && c == CH_PLUS)) begin
						if (!isdig)
							p_err = ERR_BAD_DEN;
						else
							add_digit(d);
					end
				end
			endcase
		end
		if (!lst)
			return;

		// end of string: resolve the rational or the first error
		got = 1;
		n = '0;
		dn = '0;
		if (p_err == ERR_OK) begin
			case (p_ph)
				PH_SIGN, PH_INT: begin
					if (!p_dig)
						p_err = ERR_NO_NUMBER;
					else if (p_ovf)
						p_err = ERR_TOO_LARGE;
					else begin
						n = p_acc;
						dn = 64'd1;
					end
				end
				PH_FRAC: begin
					if (!p_dig && !p_ldot)
						p_err = ERR_NO_NUMBER;
					else if (p_ovf)
						p_err = ERR_TOO_LARGE;
					else begin
						p = 64'd1;
						for (int i = 0; i < p_fcnt; i++) begin
							if (p > MAG_LIM / 64'd10)
								p_err = ERR_TOO_LARGE;
							else
								p = p * 64'd10;
						end
						n = p_acc;
						dn = p;
					end
				end
				default: begin
					if (!p_dig)
						p_err = ERR_NO_DEN;
					else if (p_ovf)
						p_err = ERR_TOO_LARGE;
					else begin
						n = p_num;
						dn = p_dneg ? -p_acc : p_acc;
					end
				end
			endcase
		end
		if (p_err == ERR_OK) begin
			res.numer = p_neg ? -n : n;
			res.denom = dn;
		end
		res.err = p_err;
		parse_clear();
	endtask

	// per-beat wait, with occasional stretches of back-to-back beats
	function automatic int draw_gap(inout bit burst);
		if ($urandom_range(0, 29) == 0)
			burst = !burst;
		return burst ? 0 : $urandom_range(0, 17);
	endfunction

	// push one string, a beat per character
	task automatic send_text(input byte unsigned txt[$], input bit known,
			input rat_res_t typed);
		int       gap;
		bit       got;
		rat_res_t res;
		n_texts++;
		for (int i = 0; i < txt.size(); i++) begin
			gap = draw_gap(snd_burst);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			s_axis_tdata  <= txt[i];
			s_axis_tlast  <= (i == txt.size() - 1);
			s_axis_tvalid <= 1'b1;
			@(posedge clk);
			while (!s_axis_tready)
				@(posedge clk);
			n_chars++;
			parse_step(txt[i], i == txt.size() - 1, got, res);
			if (got)
				rat_expect_q.push_back(known ? typed : res);
			@(negedge clk);
		end
	endtask

	task automatic push_digits(ref byte unsigned q[$], input int n);
		repeat (n)
			q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
	endtask

	task automatic push_sign(ref byte unsigned q[$]);
		case ($urandom_range(0, 3))
			0: q.push_back(CH_MINUS);
			1: q.push_back(CH_PLUS);
			default: ;
		endcase
	endtask

	function automatic int digit_len();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return $urandom_range(15, 21);
			default: return $urandom_range(1, 5);
		endcase
	endfunction

	// mostly well-formed numbers, some near the limit, some noise and damage
	task automatic gen_text(ref byte unsigned q[$]);
		string near;
		int    kind;
		near = "92233720368547758";
		q.delete();
		kind = $urandom_range(0, 19);
		if (kind < 2) begin
			repeat ($urandom_range(1, 6))
				q.push_back(8'($urandom_range(0, 255)));
		end else if (kind < 4) begin
			push_sign(q);
			for (int i = 0; i < near.len(); i++)
				q.push_back(near[i]);
			push_digits(q, $urandom_range(1, 3));
			if ($urandom_range(0, 2) == 0) begin
				q.push_back(CH_SLASH);
				push_digits(q, $urandom_range(1, 3));
			end
		end else begin
			push_sign(q);
			push_digits(q, digit_len());
			case ($urandom_range(0, 2))
				0: ;
				1: begin
					q.push_back(CH_DOT);
					push_digits(q, digit_len());
				end
				default: begin
					q.push_back(CH_SLASH);
					repeat ($urandom_range(0, 3))
						q.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
					push_digits(q, digit_len());
				end
			endcase
		end
		if (q.size() == 0)
			q.push_back(CH_DOT);
		if ($urandom_range(0, 7) == 0)
			q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
	endtask

	// main stimulus
	initial begin
		byte unsigned txt[$];
		rat_res_t     typed;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		parse_clear();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed strings
		for (int r = 0; r < N_DIR; r++) begin
			txt.delete();
			for (int i = 0; i < dir_tab[r].txt.len(); i++)
				txt.push_back(dir_tab[r].txt[i]);
			typed = '{dir_tab[r].numer, dir_tab[r].denom, dir_tab[r].err};
			send_text(txt, dir_tab[r].known, typed);
		end

		// random strings
		typed = '{64'd0, 64'd0, ERR_OK};
		while (n_chars < TEXT_ITEMS) begin
			gen_text(txt);
			send_text(txt, 0, typed);
		end
		s_axis_tvalid <= 1'b0;

		// drain, then keep watching for anything unexpected
		while (rat_expect_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Covered %0d strings, %0d characters, %0d results compared", n_texts,
			n_chars, n_results);
		$display("Error codes 0-7 seen: %0d %0d %0d %0d %0d %0d %0d %0d",
			err_hist[0], err_hist[1], err_hist[2], err_hist[3], err_hist[4], err_hist[5],
			err_hist[6], err_hist[7]);
		if (fails == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// result side ready pattern
	initial begin
		int gap;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = draw_gap(rcv_burst);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	// compare each result beat with the oldest expected rational
	always @(posedge clk) begin : mon
		rat_res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (rat_expect_q.size() == 0) begin
				$error("result beat with no string pending: numer %0d denom %0d error %0d",
					$signed(m_axis_tdata[63:0]), $signed(m_axis_tdata[127:64]),
					m_axis_tdata[130:128]);
				fails++;
			end else begin
				want = rat_expect_q.pop_front();
				n_results++;
				err_hist[want.err]++;
				if (m_axis_tdata[63:0] !== want.numer) begin
					$error("numer: expected %0d, got %0d", $signed(want.numer),
						$signed(m_axis_tdata[63:0]));
					fails++;
				end
				if (m_axis_tdata[127:64] !== want.denom) begin
					$error("denom: expected %0d, got %0d", $signed(want.denom),
						$signed(m_axis_tdata[127:64]));
					fails++;
				end
				if (m_axis_tdata[130:128] !== want.err) begin
					$error("error: expected %0d, got %0d", want.err, m_axis_tdata[130:128]);
					fails++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding", cyc,
				rat_expect_q.size());
			$display("== FAIL ==");
			$finish;
		end
	end

endmodule

[filelist.f]
hw/rtl/rtp_pkg.sv
hw/rtl/rtp_step.sv
hw/rtl/rational_text_parser_top.sv
test/rational_text_parser_top_tb.sv
